// ===== sv/gdcp_pkg.sv =====
// Shared types, constants and control store for the grid coverage planner.
// Used by every module of the block except the generic RAM.
package gdcp_pkg;

    localparam int GRID_SIDE  = 128;
    localparam int HALF_SIDE  = GRID_SIDE / 2;
    localparam int CELL_COUNT = GRID_SIDE * GRID_SIDE;
    localparam int CW         = 7;
    localparam int NB_W       = CW + 2;
    localparam int IDX_W      = 2 * CW;
    localparam int MAP_W      = 32;
    localparam int MAP_BIT_W  = 5;
    localparam int MAP_ROWS   = CELL_COUNT / MAP_W;
    localparam int ROW_W      = IDX_W - MAP_BIT_W;
    localparam int STK_W      = 5;
    localparam int DEPTH_W    = IDX_W + 1;
    localparam int CLEAN_W    = 14;
    localparam int OK_W       = 20;
    localparam int PASS_W     = 4;
    localparam int OFF_W      = 3;
    localparam int KIND_W     = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_W      = 4;
    localparam int UPC_W      = 5;
    localparam int IN_TDATA_W = 8;
    localparam int OUT_TDATA_W = 56;

    localparam logic [CLEAN_W-1:0] CLEAN_MAX  = '1;
    localparam logic [OK_W-1:0]    OK_MAX     = '1;
    localparam logic [PASS_W-1:0]  PASS_MAX   = '1;
    localparam logic [OFF_W-1:0]   OFF_LAST   = 3'd4;
    localparam logic [IDX_W-1:0]   ORIGIN_IDX = IDX_W'(HALF_SIDE * GRID_SIDE + HALF_SIDE);

    localparam logic [CFG_IDX_W-1:0] CFG_WALK_ORDER    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_PASSES = 1'b1;

    localparam logic [NB_W-1:0] STEP_X [4] = '{9'sd1, 9'sd0, -9'sd1, 9'sd0};
    localparam logic [NB_W-1:0] STEP_Y [4] = '{9'sd0, 9'sd1, 9'sd0, -9'sd1};
    localparam logic [1:0] BACK_DIR    [4] = '{2'd2, 2'd3, 2'd0, 2'd1};
    localparam logic [1:0] FIXED_ORDER [4] = '{2'd0, 2'd2, 2'd1, 2'd3};

    typedef enum logic [2:0] {
        PH_IDLE, PH_INIT, PH_ADV, PH_REPB, PH_REPF, PH_RET, PH_DONE
    } t_phase;

    typedef enum logic [KIND_W-1:0] {
        K_INIT, K_ADV, K_REPB, K_REPF, K_RET
    } t_kind;

    typedef enum logic [4:0] {
        OP_NOP, OP_WAIT, OP_START, OP_CLR_ROW, OP_EMIT_INIT, OP_CNT, OP_CNT_CLEAN,
        OP_CNT_PASS, OP_EMIT_REPB, OP_EMIT_REPF, OP_PUSH, OP_POP, OP_LOAD,
        OP_PROBE, OP_EMIT_ADV, OP_EMIT_RET, OP_EMIT_FIN
    } t_op;

    typedef enum logic [3:0] {
        C_NEVER, C_ALWAYS, C_SUCC_N, C_REP_ZERO, C_PASS_LT, C_FULL, C_DEPTH0,
        C_OFF4, C_BLOCKED, C_CLR_MORE
    } t_cond;

    typedef struct packed {
        t_op              op;
        t_cond            cond;
        logic [UPC_W-1:0] target;
    } t_uword;

    typedef struct packed {
        t_op  op;
        logic accept;
    } t_ctrl;

    typedef struct packed {
        logic   succ_n;
        logic   rep_zero;
        logic   pass_lt;
        logic   stack_full;
        logic   depth_zero;
        logic   off_ge4;
        logic   blocked;
        logic   clr_more;
        logic   out_busy;
        t_phase phase;
    } t_stat;

    localparam logic [UPC_W-1:0] A_WAIT      = 5'd0;
    localparam logic [UPC_W-1:0] A_START     = 5'd1;
    localparam logic [UPC_W-1:0] A_CLR       = 5'd2;
    localparam logic [UPC_W-1:0] A_INIT_EMIT = 5'd3;
    localparam logic [UPC_W-1:0] A_INIT      = 5'd4;
    localparam logic [UPC_W-1:0] A_INIT_CNT  = 5'd5;
    localparam logic [UPC_W-1:0] A_ADV       = 5'd6;
    localparam logic [UPC_W-1:0] A_ADV_CNT   = 5'd7;
    localparam logic [UPC_W-1:0] A_REPBK     = 5'd8;
    localparam logic [UPC_W-1:0] A_REPB      = 5'd9;
    localparam logic [UPC_W-1:0] A_REPB_EMIT = 5'd10;
    localparam logic [UPC_W-1:0] A_REPF      = 5'd11;
    localparam logic [UPC_W-1:0] A_REPF_CHK  = 5'd12;
    localparam logic [UPC_W-1:0] A_DESC      = 5'd13;
    localparam logic [UPC_W-1:0] A_PUSH      = 5'd14;
    localparam logic [UPC_W-1:0] A_RET       = 5'd15;
    localparam logic [UPC_W-1:0] A_POP       = 5'd16;
    localparam logic [UPC_W-1:0] A_LOAD      = 5'd17;
    localparam logic [UPC_W-1:0] A_SCAN      = 5'd18;
    localparam logic [UPC_W-1:0] A_PROBE     = 5'd19;
    localparam logic [UPC_W-1:0] A_TEST      = 5'd20;
    localparam logic [UPC_W-1:0] A_ADV_EMIT  = 5'd21;
    localparam logic [UPC_W-1:0] A_EXH       = 5'd22;
    localparam logic [UPC_W-1:0] A_RET_EMIT  = 5'd23;
    localparam logic [UPC_W-1:0] A_FIN       = 5'd24;

    function automatic t_uword gdcp_ucode(input logic [UPC_W-1:0] a);
        t_uword w;
        case (a)
            A_WAIT:      w = '{OP_WAIT,      C_NEVER,    A_WAIT};
            A_START:     w = '{OP_START,     C_NEVER,    A_WAIT};
            A_CLR:       w = '{OP_CLR_ROW,   C_CLR_MORE, A_CLR};
            A_INIT_EMIT: w = '{OP_EMIT_INIT, C_ALWAYS,   A_WAIT};
            A_INIT:      w = '{OP_NOP,       C_SUCC_N,   A_FIN};
            A_INIT_CNT:  w = '{OP_CNT,       C_ALWAYS,   A_SCAN};
            A_ADV:       w = '{OP_NOP,       C_SUCC_N,   A_SCAN};
            A_ADV_CNT:   w = '{OP_CNT_CLEAN, C_REP_ZERO, A_DESC};
            A_REPBK:     w = '{OP_EMIT_REPB, C_ALWAYS,   A_WAIT};
            A_REPB:      w = '{OP_CNT,       C_NEVER,    A_WAIT};
            A_REPB_EMIT: w = '{OP_EMIT_REPF, C_ALWAYS,   A_WAIT};
            A_REPF:      w = '{OP_CNT_PASS,  C_NEVER,    A_WAIT};
            A_REPF_CHK:  w = '{OP_NOP,       C_PASS_LT,  A_REPBK};
            A_DESC:      w = '{OP_NOP,       C_FULL,     A_SCAN};
            A_PUSH:      w = '{OP_PUSH,      C_ALWAYS,   A_SCAN};
            A_RET:       w = '{OP_CNT,       C_DEPTH0,   A_SCAN};
            A_POP:       w = '{OP_POP,       C_NEVER,    A_WAIT};
            A_LOAD:      w = '{OP_LOAD,      C_ALWAYS,   A_SCAN};
            A_SCAN:      w = '{OP_NOP,       C_OFF4,     A_EXH};
            A_PROBE:     w = '{OP_PROBE,     C_NEVER,    A_WAIT};
            A_TEST:      w = '{OP_NOP,       C_BLOCKED,  A_SCAN};
            A_ADV_EMIT:  w = '{OP_EMIT_ADV,  C_ALWAYS,   A_WAIT};
            A_EXH:       w = '{OP_NOP,       C_DEPTH0,   A_FIN};
            A_RET_EMIT:  w = '{OP_EMIT_RET,  C_ALWAYS,   A_WAIT};
            A_FIN:       w = '{OP_EMIT_FIN,  C_ALWAYS,   A_WAIT};
            default:     w = '{OP_NOP,       C_ALWAYS,   A_WAIT};
        endcase
        return w;
    endfunction

    function automatic logic [UPC_W-1:0] gdcp_dispatch(input logic func, input t_phase ph);
        logic [UPC_W-1:0] a;
        if (!func) begin
            a = A_START;
        end else begin
            case (ph)
                PH_INIT: a = A_INIT;
                PH_ADV:  a = A_ADV;
                PH_REPB: a = A_REPB;
                PH_REPF: a = A_REPF;
                PH_RET:  a = A_RET;
                default: a = A_WAIT;
            endcase
        end
        return a;
    endfunction

    function automatic logic gdcp_is_emit(input t_op op);
        return (op == OP_EMIT_INIT) || (op == OP_EMIT_REPB) || (op == OP_EMIT_REPF) ||
               (op == OP_EMIT_ADV) || (op == OP_EMIT_RET) || (op == OP_EMIT_FIN);
    endfunction

    function automatic logic [1:0] gdcp_dir_of(input logic walk, input logic [1:0] cdir,
                                               input logic [1:0] off);
        logic [1:0] d;
        if (walk) begin
            d = FIXED_ORDER[off];
        end else begin
            d = cdir + off;
        end
        return d;
    endfunction

endpackage

// ===== sv/gdcp_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; no package dependencies.
module gdcp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

// ===== sv/gdcp_useq.sv =====
// Microcode sequencer: step counter, control store lookup, jumps and dispatch.
// Depends on gdcp_pkg for the control store, opcodes and status struct.
module gdcp_useq
    import gdcp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_tvalid,
    input  logic  i_func,
    output logic  o_tready,
    input  t_stat i_stat,
    output t_ctrl o_ctrl
);

    logic [UPC_W-1:0] r_upc, n_upc;
    t_uword           uw;
    logic             stall;
    logic             cond_ok;
    logic             accept;

    always_comb begin
        uw       = gdcp_ucode(r_upc);
        stall    = gdcp_is_emit(uw.op) && i_stat.out_busy;
        o_tready = (uw.op == OP_WAIT);
        accept   = o_tready && i_tvalid;
    end

    always_comb begin
        case (uw.cond)
            C_NEVER:    cond_ok = 1'b0;
            C_ALWAYS:   cond_ok = 1'b1;
            C_SUCC_N:   cond_ok = i_stat.succ_n;
            C_REP_ZERO: cond_ok = i_stat.rep_zero;
            C_PASS_LT:  cond_ok = i_stat.pass_lt;
            C_FULL:     cond_ok = i_stat.stack_full;
            C_DEPTH0:   cond_ok = i_stat.depth_zero;
            C_OFF4:     cond_ok = i_stat.off_ge4;
            C_BLOCKED:  cond_ok = i_stat.blocked;
            C_CLR_MORE: cond_ok = i_stat.clr_more;
            default:    cond_ok = 1'b0;
        endcase
    end

    always_comb begin
        if (uw.op == OP_WAIT) begin
            n_upc = accept ? gdcp_dispatch(i_func, i_stat.phase) : r_upc;
        end else if (stall) begin
            n_upc = r_upc;
        end else if (cond_ok) begin
            n_upc = uw.target;
        end else begin
            n_upc = r_upc + UPC_W'(1);
        end
    end

    always_comb begin
        o_ctrl.op     = stall ? OP_NOP : uw.op;
        o_ctrl.accept = accept;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= A_WAIT;
        end else begin
            r_upc <= n_upc;
        end
    end

endmodule

// ===== sv/gdcp_dpath.sv =====
// Planner datapath: position, search stack, visited bitmap, counters, result register.
// Depends on gdcp_pkg; holds two gdcp_ram instances.
module gdcp_dpath
    import gdcp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_succ,
    input  t_ctrl                i_ctrl,
    output t_stat                o_stat,
    input  logic                 i_m_tready,
    output logic                 o_m_tvalid,
    output logic signed [CW-1:0] o_target_x,
    output logic signed [CW-1:0] o_target_y,
    output logic [1:0]           o_heading,
    output t_kind                o_move_kind,
    output logic                 o_long_wait,
    output logic                 o_finished,
    output logic [CLEAN_W-1:0]   o_cells_cleaned,
    output logic [OK_W-1:0]      o_moves_ok
);

    t_phase               r_phase, n_phase;
    logic [CW-1:0]        r_cx, n_cx, r_cy, n_cy;
    logic [1:0]           r_dir, n_dir;
    logic [OFF_W-1:0]     r_off, n_off;
    logic [PASS_W-1:0]    r_pass, n_pass;
    logic [CLEAN_W-1:0]   r_clean, n_clean;
    logic [OK_W-1:0]      r_ok, n_ok;
    logic [DEPTH_W-1:0]   r_depth, n_depth;
    logic [ROW_W-1:0]     r_clr, n_clr;
    logic                 r_full, n_full;
    logic                 r_succ;
    logic                 r_walk;
    logic [CFG_W-1:0]     r_reps;

    logic [CW-1:0]        r_nx, n_nx, r_ny, n_ny;
    logic [1:0]           r_nd, n_nd;
    logic                 r_inb, n_inb;
    logic [IDX_W-1:0]     r_idx, n_idx;

    logic [CW-1:0]        r_ox, r_oy;
    logic [1:0]           r_oh;
    t_kind                r_okind;
    logic                 r_olw, r_ofin;
    logic [CLEAN_W-1:0]   r_oclean;
    logic [OK_W-1:0]      r_ook;

    logic                 emit;
    logic [CW-1:0]        e_x, e_y;
    logic [1:0]           e_h;
    t_kind                e_kind;
    logic                 e_lw, e_fin;

    logic [1:0]           pend_off, pdir, qdir;
    logic [NB_W-1:0]      cx9, cy9, gx, gy;
    logic [DEPTH_W-1:0]   depth_m1;
    logic [OFF_W-1:0]     ld_off;
    logic [OK_W-1:0]      ok_inc;

    logic                 map_we, map_re;
    logic [ROW_W-1:0]     map_waddr, map_raddr;
    logic [MAP_W-1:0]     map_wdata, map_rdata;
    logic                 stk_we, stk_re;
    logic [STK_W-1:0]     stk_rdata;

    always_comb begin
        pend_off = (r_off == '0) ? 2'd0 : r_off[1:0] - 2'd1;
        pdir     = gdcp_dir_of(r_walk, r_dir, pend_off);
        qdir     = gdcp_dir_of(r_walk, r_dir, r_off[1:0]);
        cx9      = {{2{r_cx[CW-1]}}, r_cx};
        cy9      = {{2{r_cy[CW-1]}}, r_cy};
        gx       = cx9 + STEP_X[qdir] + NB_W'(HALF_SIDE);
        gy       = cy9 + STEP_Y[qdir] + NB_W'(HALF_SIDE);
        depth_m1 = r_depth - DEPTH_W'(1);
        ld_off   = (stk_rdata[STK_W-1:2] > OFF_LAST) ? OFF_LAST : stk_rdata[STK_W-1:2];
        ok_inc   = (r_ok != OK_MAX) ? r_ok + OK_W'(1) : r_ok;
    end

    // visited bitmap, 32 cells per row
    always_comb begin
        map_we    = 1'b0;
        map_waddr = r_clr;
        map_wdata = '0;
        map_re    = 1'b0;
        map_raddr = {gx[CW-1:0], gy[CW-1:MAP_BIT_W]};
        case (i_ctrl.op)
            OP_CLR_ROW: begin
                map_we = 1'b1;
            end
            OP_EMIT_INIT: begin
                map_we    = 1'b1;
                map_waddr = ORIGIN_IDX[IDX_W-1:MAP_BIT_W];
                map_wdata = MAP_W'(1) << ORIGIN_IDX[MAP_BIT_W-1:0];
            end
            OP_PROBE: begin
                map_re = 1'b1;
            end
            OP_EMIT_ADV: begin
                map_we    = 1'b1;
                map_waddr = r_idx[IDX_W-1:MAP_BIT_W];
                map_wdata = map_rdata | (MAP_W'(1) << r_idx[MAP_BIT_W-1:0]);
            end
            default: begin
                map_we = 1'b0;
            end
        endcase
    end

    gdcp_ram #(.WIDTH(MAP_W), .DEPTH(MAP_ROWS)) u_map (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_re    (map_re),
        .i_raddr (map_raddr),
        .o_rdata (map_rdata)
    );

    always_comb begin
        stk_we = (i_ctrl.op == OP_PUSH);
        stk_re = (i_ctrl.op == OP_POP);
    end

    gdcp_ram #(.WIDTH(STK_W), .DEPTH(CELL_COUNT)) u_stack (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (r_depth[IDX_W-1:0]),
        .i_wdata ({r_off, r_dir}),
        .i_re    (stk_re),
        .i_raddr (depth_m1[IDX_W-1:0]),
        .o_rdata (stk_rdata)
    );

    always_comb begin
        n_phase = r_phase;
        n_cx    = r_cx;
        n_cy    = r_cy;
        n_dir   = r_dir;
        n_off   = r_off;
        n_pass  = r_pass;
        n_clean = r_clean;
        n_ok    = r_ok;
        n_depth = r_depth;
        n_clr   = r_clr;
        n_nx    = r_nx;
        n_ny    = r_ny;
        n_nd    = r_nd;
        n_inb   = r_inb;
        n_idx   = r_idx;
        emit    = 1'b0;
        e_x     = '0;
        e_y     = '0;
        e_h     = '0;
        e_kind  = K_INIT;
        e_lw    = 1'b0;
        e_fin   = 1'b0;
        case (i_ctrl.op)
            OP_START: begin
                n_cx    = '0;
                n_cy    = '0;
                n_dir   = '0;
                n_off   = '0;
                n_pass  = '0;
                n_clean = '0;
                n_ok    = '0;
                n_depth = '0;
                n_clr   = '0;
            end
            OP_CLR_ROW: begin
                n_clr = r_clr + ROW_W'(1);
            end
            OP_EMIT_INIT: begin
                n_phase = PH_INIT;
                emit    = 1'b1;
                e_lw    = 1'b1;
            end
            OP_CNT: begin
                if (r_succ) begin
                    n_ok = ok_inc;
                end
            end
            OP_CNT_CLEAN: begin
                n_ok    = ok_inc;
                n_clean = (r_clean != CLEAN_MAX) ? r_clean + CLEAN_W'(1) : r_clean;
                n_pass  = '0;
            end
            OP_CNT_PASS: begin
                if (r_succ) begin
                    n_ok = ok_inc;
                end
                n_pass = (r_pass != PASS_MAX) ? r_pass + PASS_W'(1) : r_pass;
            end
            OP_EMIT_REPB: begin
                n_phase = PH_REPB;
                emit    = 1'b1;
                e_x     = r_cx;
                e_y     = r_cy;
                e_h     = BACK_DIR[pdir];
                e_kind  = K_REPB;
            end
            OP_EMIT_REPF: begin
                n_phase = PH_REPF;
                emit    = 1'b1;
                e_x     = r_cx + STEP_X[pdir][CW-1:0];
                e_y     = r_cy + STEP_Y[pdir][CW-1:0];
                e_h     = pdir;
                e_kind  = K_REPF;
            end
            OP_PUSH: begin
                n_depth = r_depth + DEPTH_W'(1);
                n_cx    = r_cx + STEP_X[pdir][CW-1:0];
                n_cy    = r_cy + STEP_Y[pdir][CW-1:0];
                n_dir   = pdir;
                n_off   = '0;
            end
            OP_POP: begin
                n_depth = depth_m1;
                n_cx    = r_cx - STEP_X[r_dir][CW-1:0];
                n_cy    = r_cy - STEP_Y[r_dir][CW-1:0];
            end
            OP_LOAD: begin
                n_dir = stk_rdata[1:0];
                n_off = ld_off;
            end
            OP_PROBE: begin
                n_nx  = r_cx + STEP_X[qdir][CW-1:0];
                n_ny  = r_cy + STEP_Y[qdir][CW-1:0];
                n_nd  = qdir;
                n_inb = (gx < NB_W'(GRID_SIDE)) && (gy < NB_W'(GRID_SIDE));
                n_idx = {gx[CW-1:0], gy[CW-1:0]};
                n_off = r_off + OFF_W'(1);
            end
            OP_EMIT_ADV: begin
                n_phase = PH_ADV;
                emit    = 1'b1;
                e_x     = r_nx;
                e_y     = r_ny;
                e_h     = r_nd;
                e_kind  = K_ADV;
            end
            OP_EMIT_RET: begin
                n_phase = PH_RET;
                emit    = 1'b1;
                e_x     = r_cx - STEP_X[r_dir][CW-1:0];
                e_y     = r_cy - STEP_Y[r_dir][CW-1:0];
                e_h     = BACK_DIR[r_dir];
                e_kind  = K_RET;
            end
            OP_EMIT_FIN: begin
                n_phase = PH_DONE;
                emit    = 1'b1;
                e_fin   = 1'b1;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
        if (emit) begin
            n_full = 1'b1;
        end else if (i_m_tready) begin
            n_full = 1'b0;
        end else begin
            n_full = r_full;
        end
    end

    always_comb begin
        o_stat.succ_n     = !r_succ;
        o_stat.rep_zero   = (r_reps == '0);
        o_stat.pass_lt    = (r_pass < r_reps);
        o_stat.stack_full = (r_depth == DEPTH_W'(CELL_COUNT));
        o_stat.depth_zero = (r_depth == '0);
        o_stat.off_ge4    = (r_off >= OFF_LAST);
        o_stat.blocked    = !r_inb || map_rdata[r_idx[MAP_BIT_W-1:0]];
        o_stat.clr_more   = (r_clr != ROW_W'(MAP_ROWS - 1));
        o_stat.out_busy   = r_full && !i_m_tready;
        o_stat.phase      = r_phase;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_cx    <= '0;
            r_cy    <= '0;
            r_dir   <= '0;
            r_off   <= '0;
            r_pass  <= '0;
            r_clean <= '0;
            r_ok    <= '0;
            r_depth <= '0;
            r_clr   <= '0;
            r_full  <= 1'b0;
            r_walk  <= 1'b0;
            r_reps  <= '0;
        end else begin
            r_phase <= n_phase;
            r_cx    <= n_cx;
            r_cy    <= n_cy;
            r_dir   <= n_dir;
            r_off   <= n_off;
            r_pass  <= n_pass;
            r_clean <= n_clean;
            r_ok    <= n_ok;
            r_depth <= n_depth;
            r_clr   <= n_clr;
            r_full  <= n_full;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_WALK_ORDER:    r_walk <= i_cfg_data[0];
                    CFG_REPEAT_PASSES: r_reps <= i_cfg_data;
                    default:           r_walk <= r_walk;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.accept) begin
            r_succ <= i_succ;
        end
        r_nx  <= n_nx;
        r_ny  <= n_ny;
        r_nd  <= n_nd;
        r_inb <= n_inb;
        r_idx <= n_idx;
        if (emit) begin
            r_ox     <= e_x;
            r_oy     <= e_y;
            r_oh     <= e_h;
            r_okind  <= e_kind;
            r_olw    <= e_lw;
            r_ofin   <= e_fin;
            r_oclean <= r_clean;
            r_ook    <= r_ok;
        end
    end

    always_comb begin
        o_m_tvalid      = r_full;
        o_target_x      = r_ox;
        o_target_y      = r_oy;
        o_heading       = r_oh;
        o_move_kind     = r_okind;
        o_long_wait     = r_olw;
        o_finished      = r_ofin;
        o_cells_cleaned = r_oclean;
        o_moves_ok      = r_ook;
    end

endmodule

// ===== sv/grid_dfs_coverage_planner.sv =====
// Top level of the depth-first grid coverage planner: stream ports and config port.
// Depends on gdcp_pkg, gdcp_useq and gdcp_dpath.
//
//  channel   direction  handshake                    contents
//  s_axis    in         s_axis_tvalid/s_axis_tready  start command or move outcome
//  m_axis    out        m_axis_tvalid/m_axis_tready  next move request or done mark
//  cfg       in         i_cfg_we                     walk_order, repeat_passes
//
//  A start command sweeps the visited bitmap clear, one 32-cell row per cycle,
//  before the initial move comes out. An outcome runs through the microcode
//  steps: three per neighbor probe (scan, probe, test) through the registered
//  bitmap read, two more per stack pop (pop, load). Reset is synchronous, active
//  low, and leaves the planner idle. The result register lets the next item in
//  while a result waits; the sequencer holds on its emit step until it drains.
module grid_dfs_coverage_planner
    import gdcp_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [0] succeeded, rest zero
    input  logic                   s_axis_tuser,   // [0] func
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // target_x, target_y, heading,
                                                   // long_wait, cells_cleaned, moves_ok
    output logic [KIND_W-1:0]      m_axis_tuser,   // [2:0] move_kind
    output logic                   m_axis_tlast,   // finished
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_W-1:0]       i_cfg_data
);

    t_ctrl                ctrl;
    t_stat                stat;
    logic signed [CW-1:0] target_x, target_y;
    logic [1:0]           heading;
    t_kind                move_kind;
    logic                 long_wait, finished;
    logic [CLEAN_W-1:0]   cells_cleaned;
    logic [OK_W-1:0]      moves_ok;

    gdcp_useq u_useq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (s_axis_tvalid),
        .i_func   (s_axis_tuser),
        .o_tready (s_axis_tready),
        .i_stat   (stat),
        .o_ctrl   (ctrl)
    );

    gdcp_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_succ          (s_axis_tdata[0]),
        .i_ctrl          (ctrl),
        .o_stat          (stat),
        .i_m_tready      (m_axis_tready),
        .o_m_tvalid      (m_axis_tvalid),
        .o_target_x      (target_x),
        .o_target_y      (target_y),
        .o_heading       (heading),
        .o_move_kind     (move_kind),
        .o_long_wait     (long_wait),
        .o_finished      (finished),
        .o_cells_cleaned (cells_cleaned),
        .o_moves_ok      (moves_ok)
    );

    always_comb begin
        m_axis_tdata = {5'd0, moves_ok, cells_cleaned, long_wait, heading,
                        target_y, target_x};
        m_axis_tuser = move_kind;
        m_axis_tlast = finished;
    end

    a_no_emit_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.out_busy |-> !gdcp_is_emit(ctrl.op))
        else $error("result overwritten while the output register is stalled");

    a_start_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && !s_axis_tuser) |=> (ctrl.op == OP_START))
        else $error("start item did not enter the start routine");

    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctrl.op == OP_PUSH) |-> !stat.stack_full)
        else $error("push into a full path stack");

    a_busy_holds_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.out_busy |=> m_axis_tvalid)
        else $error("stalled result dropped");

endmodule
